>>> sv/consistent_hash_routed_lru_cache_top_assert.svh
// Assertion macros for the routed LRU cache checker.
// Needs nothing else; included by the checker file.
`ifndef CONSISTENT_HASH_ROUTED_LRU_CACHE_TOP_ASSERT_SVH
`define CONSISTENT_HASH_ROUTED_LRU_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CHRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("routed cache check failed");

// Next-cycle implication, held off during reset.
`define CHRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("routed cache check failed");

`endif

>>> sv/chrlc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the routed LRU cache.
// No dependencies; used by every other file but the assertion header.
package chrlc_pkg;

    localparam int NODES_DEF   = 4;
    localparam int ENTRIES_DEF = 128;
    localparam int VNODES      = 3;
    localparam int RING_MOD    = 1000;
    localparam int POS_W       = 10;
    localparam int MAX_SLOTS   = 4;
    localparam int RING_W      = VNODES * POS_W;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_GET_HIT    = 3'd0,
        ST_GET_MISS   = 3'd1,
        ST_SET_UPDATE = 3'd2,
        ST_SET_INSERT = 3'd3,
        ST_SET_EVICT  = 3'd4,
        ST_NO_NODE    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_NODE_COUNT = 3'd0,
        CFG_RING_SLOT0 = 3'd1,
        CFG_RING_SLOT1 = 3'd2,
        CFG_RING_SLOT2 = 3'd3,
        CFG_RING_SLOT3 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        kind;
        logic [63:0] key_tag;
        logic [9:0]  key_ring_hash;
        logic [63:0] write_value;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [1:0]  node_slot;
        logic [63:0] read_value;
        logic [7:0]  node_entry_count;
        logic [31:0] node_hits;
        logic [31:0] node_misses;
        logic [31:0] node_evictions;
        logic [31:0] total_requests;
        logic [31:0] total_hits;
    } t_result;

    // Running best vnode handed along the routing chain.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] best;
        logic [1:0]       owner;
    } t_route;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] stamp;
    } t_entry;

    // Fold a 10-bit position onto the ring; it stays below twice the modulus.
    function automatic logic [POS_W-1:0] reduce_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        r = (p >= POS_W'(RING_MOD)) ? p - POS_W'(RING_MOD) : p;
        return r;
    endfunction

endpackage

>>> sv/consistent_hash_routed_lru_cache_top.sv
`timescale 1ns / 1ps
// Top level of the consistent-hash routed LRU key/value cache.
// Depends on chrlc_pkg, chrlc_ring_cell and chrlc_table.
//
//  channel   | direction | handshake                    | beat
//  ----------+-----------+------------------------------+-------------------
//  item      | in        | start high while busy low    | i_item (t_item)
//  result    | out       | o_result_strobe, one cycle   | o_result (t_result)
//  config    | in        | i_cfg_valid and o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item stays in S_ROUTE while the owner passes the four ring
// cells. It then walks the routed node's table through the single read port.
// The match scan reads the node's filled entries in order and stops on a match.
// A set of a key not found in a full table adds an oldest-stamp pass and a
// shift pass that moves later entries down. S_FIN then forms the result.
// Reset is synchronous and active low; it clears fill counts and counters,
// the entry memory needs no clearing. The result receiver cannot stall; the
// result register lets the next start be taken in the cycle it is shown.
module consistent_hash_routed_lru_cache_top #(
    parameter int NODES   = chrlc_pkg::NODES_DEF,
    parameter int ENTRIES = chrlc_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  chrlc_pkg::t_item              i_item,
    output logic                          o_result_strobe,
    output chrlc_pkg::t_result            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [chrlc_pkg::RING_W-1:0]  i_cfg_data
);

    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int IW    = $clog2(ENTRIES);
    localparam int FW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = NODES * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(chrlc_pkg::MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUTE,
        S_SCAN,
        S_EVICT,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_cnt;
    logic                          r_kind;
    logic [63:0]                   r_key;
    logic [63:0]                   r_wval;
    logic [chrlc_pkg::POS_W-1:0]   r_kpos;
    logic [NW-1:0]                 r_node;
    logic [FW-1:0]                 r_idx;
    logic                          r_pend;
    logic [IW-1:0]                 r_pidx;
    logic [31:0]                   r_min;
    logic [IW-1:0]                 r_lru;
    chrlc_pkg::t_status            r_status;
    logic [63:0]                   r_rval;
    logic [2:0]                    r_node_count;
    logic [FW-1:0]                 r_fill  [NODES];
    logic [31:0]                   r_hits  [NODES];
    logic [31:0]                   r_miss  [NODES];
    logic [31:0]                   r_evict [NODES];
    logic [31:0]                   r_req_total;
    logic [31:0]                   r_hit_total;
    logic [31:0]                   r_stamp;
    chrlc_pkg::t_result            r_result;
    logic                          r_strobe;

    chrlc_pkg::t_route             route_link [chrlc_pkg::MAX_SLOTS + 1];
    chrlc_pkg::t_entry             rdata;
    chrlc_pkg::t_entry             new_entry;
    chrlc_pkg::t_entry             mem_wdata;
    logic                          mem_we;
    logic [IW-1:0]                 w_idx;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [FW-1:0]                 fill_cur;
    logic                          key_match;
    logic                          pass_end;
    logic                          room;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);

    // Routing chain: an empty route enters at cell 0, every cell sees the key
    // position, and the best owner moves one cell per cycle.
    assign route_link[0] = '0;

    for (genvar s = 0; s < chrlc_pkg::MAX_SLOTS; s++) begin : g_cell
        chrlc_ring_cell #(
            .SLOT (2'(s))
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg_we   (i_cfg_valid && (i_cfg_index == 3'(chrlc_pkg::CFG_RING_SLOT0 + s))),
            .i_cfg_data (i_cfg_data),
            .i_active   ((32'(r_node_count) > s) && (NODES > s)),
            .i_kpos     (r_kpos),
            .i_route    (route_link[s]),
            .o_route    (route_link[s+1])
        );
    end

    chrlc_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    assign fill_cur  = r_fill[r_node];
    assign key_match = r_pend && (rdata.key == r_key);
    assign pass_end  = !r_pend && (r_idx >= ((r_state == S_SCAN) ? fill_cur : FW'(ENTRIES)));
    assign room      = (fill_cur < FW'(ENTRIES));
    assign new_entry = '{key: r_key, value: r_wval, stamp: r_stamp};
    assign mem_raddr = AW'(r_node) * AW'(ENTRIES) + AW'(r_idx[IW-1:0]);
    assign mem_waddr = AW'(r_node) * AW'(ENTRIES) + AW'(w_idx);

    // Write port: stamp a hit, update or append in the scan; move an entry
    // down or append at the top in the shift pass.
    always_comb begin
        mem_we    = 1'b0;
        w_idx     = r_pidx;
        mem_wdata = new_entry;
        case (r_state)
            S_SCAN: begin
                if (key_match) begin
                    mem_we = 1'b1;
                    if (r_kind == chrlc_pkg::KIND_GET) begin
                        mem_wdata = '{key: rdata.key, value: rdata.value, stamp: r_stamp};
                    end
                end else if (pass_end && r_kind == chrlc_pkg::KIND_SET && room) begin
                    mem_we = 1'b1;
                    w_idx  = fill_cur[IW-1:0];
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    w_idx     = r_pidx - IW'(1);
                    mem_wdata = rdata;
                end else if (pass_end) begin
                    mem_we = 1'b1;
                    w_idx  = IW'(ENTRIES - 1);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_node_count <= '0;
            r_req_total  <= '0;
            r_hit_total  <= '0;
            r_stamp      <= '0;
            r_pend       <= 1'b0;
            r_cnt        <= '0;
            for (int n = 0; n < NODES; n++) begin
                r_fill[n]  <= '0;
                r_hits[n]  <= '0;
                r_miss[n]  <= '0;
                r_evict[n] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && i_cfg_index == chrlc_pkg::CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data[2:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind <= i_item.kind;
                        r_key  <= i_item.key_tag;
                        r_wval <= i_item.write_value;
                        r_kpos <= chrlc_pkg::reduce_pos(i_item.key_ring_hash);
                        r_rval <= '0;
                        r_cnt  <= '0;
                        if (i_item.kind == chrlc_pkg::KIND_GET) begin
                            r_req_total <= r_req_total + 32'd1;
                        end
                        r_state <= S_ROUTE;
                    end
                end
                S_ROUTE: begin
                    // Hold until the owner has passed the last cell.
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(chrlc_pkg::MAX_SLOTS)) begin
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (!route_link[chrlc_pkg::MAX_SLOTS].found) begin
                            r_status <= chrlc_pkg::ST_NO_NODE;
                            r_state  <= S_FIN;
                        end else begin
                            r_node  <= NW'(route_link[chrlc_pkg::MAX_SLOTS].owner);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend <= (r_idx < fill_cur);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < fill_cur) begin
                        r_idx <= r_idx + FW'(1);
                    end
                    if (key_match) begin
                        r_stamp <= r_stamp + 32'd1;
                        if (r_kind == chrlc_pkg::KIND_GET) begin
                            r_rval         <= rdata.value;
                            r_hits[r_node] <= r_hits[r_node] + 32'd1;
                            r_hit_total    <= r_hit_total + 32'd1;
                            r_status       <= chrlc_pkg::ST_GET_HIT;
                        end else begin
                            r_status <= chrlc_pkg::ST_SET_UPDATE;
                        end
                        r_state <= S_FIN;
                    end else if (pass_end) begin
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (r_kind == chrlc_pkg::KIND_GET) begin
                            r_miss[r_node] <= r_miss[r_node] + 32'd1;
                            r_status       <= chrlc_pkg::ST_GET_MISS;
                            r_state        <= S_FIN;
                        end else if (room) begin
                            r_fill[r_node] <= fill_cur + FW'(1);
                            r_stamp        <= r_stamp + 32'd1;
                            r_status       <= chrlc_pkg::ST_SET_INSERT;
                            r_state        <= S_FIN;
                        end else begin
                            r_state <= S_EVICT;
                        end
                    end
                end
                S_EVICT: begin
                    // Track the smallest stamp, lowest index on ties.
                    r_pend <= (r_idx < FW'(ENTRIES));
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < FW'(ENTRIES)) begin
                        r_idx <= r_idx + FW'(1);
                    end
                    if (r_pend && (r_pidx == '0 || rdata.stamp < r_min)) begin
                        r_min <= rdata.stamp;
                        r_lru <= r_pidx;
                    end
                    if (pass_end) begin
                        r_idx   <= FW'(r_lru) + FW'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_pend <= (r_idx < FW'(ENTRIES));
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < FW'(ENTRIES)) begin
                        r_idx <= r_idx + FW'(1);
                    end
                    if (pass_end) begin
                        r_fill[r_node]  <= FW'(ENTRIES);
                        r_evict[r_node] <= r_evict[r_node] + 32'd1;
                        r_stamp         <= r_stamp + 32'd1;
                        r_status        <= chrlc_pkg::ST_SET_EVICT;
                        r_state         <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_result.status         <= r_status;
                    r_result.read_value     <= r_rval;
                    r_result.total_requests <= r_req_total;
                    r_result.total_hits     <= r_hit_total;
                    if (r_status == chrlc_pkg::ST_NO_NODE) begin
                        r_result.node_slot        <= '0;
                        r_result.node_entry_count <= '0;
                        r_result.node_hits        <= '0;
                        r_result.node_misses      <= '0;
                        r_result.node_evictions   <= '0;
                    end else begin
                        r_result.node_slot        <= 2'(r_node);
                        r_result.node_entry_count <= 8'(fill_cur);
                        r_result.node_hits        <= r_hits[r_node];
                        r_result.node_misses      <= r_miss[r_node];
                        r_result.node_evictions   <= r_evict[r_node];
                    end
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

>>> sv/chrlc_ring_cell.sv
`timescale 1ns / 1ps
// One routing cell: holds the vnode positions of one slot and updates the best owner.
// Depends on chrlc_pkg.
module chrlc_ring_cell #(
    parameter logic [1:0] SLOT = 2'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [chrlc_pkg::RING_W-1:0]  i_cfg_data,
    input  logic                          i_active,
    input  logic [chrlc_pkg::POS_W-1:0]   i_kpos,
    input  chrlc_pkg::t_route             i_route,
    output chrlc_pkg::t_route             o_route
);

    logic [chrlc_pkg::RING_W-1:0] r_ring;
    chrlc_pkg::t_route            r_route;
    chrlc_pkg::t_route            n_route;

    always_comb begin
        logic [chrlc_pkg::POS_W-1:0] p;
        logic [chrlc_pkg::POS_W-1:0] d;
        n_route = i_route;
        for (int j = 0; j < chrlc_pkg::VNODES; j++) begin
            p = chrlc_pkg::reduce_pos(r_ring[j*chrlc_pkg::POS_W +: chrlc_pkg::POS_W]);
            d = (p >= i_kpos) ? p - i_kpos
                              : p + chrlc_pkg::POS_W'(chrlc_pkg::RING_MOD) - i_kpos;
            if (i_active && (!n_route.found || d < n_route.best)) begin
                n_route.found = 1'b1;
                n_route.best  = d;
                n_route.owner = SLOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring  <= '0;
            r_route <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ring <= i_cfg_data;
            end
            r_route <= n_route;
        end
    end

    assign o_route = r_route;

endmodule

>>> sv/chrlc_table.sv
`timescale 1ns / 1ps
// Entry memory of all nodes: one write port, one registered read port.
// Depends on chrlc_pkg.
module chrlc_table #(
    parameter int DEPTH = chrlc_pkg::NODES_DEF * chrlc_pkg::ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  chrlc_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output chrlc_pkg::t_entry  o_rdata
);

    chrlc_pkg::t_entry r_mem [DEPTH];
    chrlc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/chrlc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the routed LRU cache, bound to the top level.
// Depends on chrlc_pkg and consistent_hash_routed_lru_cache_top_assert.svh.
`include "consistent_hash_routed_lru_cache_top_assert.svh"

module chrlc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_strobe,
    input chrlc_pkg::t_result o_result
);

    `CHRLC_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    `CHRLC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_strobe, !o_result_strobe)
    `CHRLC_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy || start)
    `CHRLC_ASSERT_NOW(a_no_node_zero, i_clk, i_rst_n, o_result_strobe && o_result.status == chrlc_pkg::ST_NO_NODE, o_result.node_slot == 2'd0 && o_result.node_entry_count == 8'd0)

endmodule

bind consistent_hash_routed_lru_cache_top chrlc_checker u_chrlc_checker (.*);

>>> tb/sv/tb_consistent_hash_routed_lru_cache_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the consistent-hash routed LRU cache top level.
// Depends on chrlc_pkg and consistent_hash_routed_lru_cache_top; a built-in predictor checks every result.
module tb_consistent_hash_routed_lru_cache_top;
    import chrlc_pkg::*;

    localparam int SLOTS = 4;
    localparam int DEPTH = 128;
    localparam int DRAIN_CYCLES = 3 * DEPTH + 40;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_item           i_item;
    logic            o_result_strobe;
    t_result         o_result;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [2:0]      i_cfg_index;
    logic [RING_W-1:0] i_cfg_data;

    consistent_hash_routed_lru_cache_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Free-running clock, 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the cache: config, tables, counters and stamp.
    // ---------------------------------------------------------------
    logic [2:0]        nodes_in_use;
    logic [RING_W-1:0] ring_cfg [SLOTS];
    logic [63:0]       tag_mem  [SLOTS][DEPTH];
    logic [63:0]       data_mem [SLOTS][DEPTH];
    logic [31:0]       age_mem  [SLOTS][DEPTH];
    int unsigned       fill     [SLOTS];
    logic [31:0]       hit_cnt  [SLOTS];
    logic [31:0]       miss_cnt [SLOTS];
    logic [31:0]       evict_cnt[SLOTS];
    logic [31:0]       req_sum;
    logic [31:0]       hit_sum;
    logic [31:0]       next_stamp;

    t_result pending_results[$];
    int      mismatches;
    int      items_sent;
    int      evictions_seen;
    int      hits_seen;

    // Pick the slot owning the nearest clockwise vnode; -1 with no node in use.
    function automatic int ring_owner(input logic [9:0] hash);
        int used, k, p, d, best, owner;
        used  = (nodes_in_use > SLOTS) ? SLOTS : nodes_in_use;
        k     = int'(hash) % RING_MOD;
        best  = 32'h7fffffff;
        owner = -1;
        for (int s = 0; s < used; s++) begin
            for (int j = 0; j < VNODES; j++) begin
                p = int'(ring_cfg[s][POS_W*j +: POS_W]) % RING_MOD;
                d = (p + RING_MOD - k) % RING_MOD;
                if (d < best) begin
                    best  = d;
                    owner = s;
                end
            end
        end
        return owner;
    endfunction

    // Apply one get or set to the shadow cache and form its result.
    function automatic t_result cache_access(input t_item it);
        t_result r;
        int n, idx, lru;
        logic [31:0] oldest;
        r = '0;
        if (it.kind == KIND_GET) req_sum = req_sum + 1;
        n = ring_owner(it.key_ring_hash);
        if (n < 0) begin
            r.status         = ST_NO_NODE;
            r.total_requests = req_sum;
            r.total_hits     = hit_sum;
            return r;
        end
        idx = -1;
        for (int i = 0; i < fill[n]; i++)
            if (idx < 0 && tag_mem[n][i] == it.key_tag) idx = i;
        if (it.kind == KIND_GET) begin
            if (idx >= 0) begin
                r.read_value   = data_mem[n][idx];
                age_mem[n][idx] = next_stamp;
                next_stamp     = next_stamp + 1;
                hit_cnt[n]     = hit_cnt[n] + 1;
                hit_sum        = hit_sum + 1;
                r.status       = ST_GET_HIT;
            end else begin
                miss_cnt[n] = miss_cnt[n] + 1;
                r.status    = ST_GET_MISS;
            end
        end else if (idx >= 0) begin
            data_mem[n][idx] = it.write_value;
            age_mem[n][idx]  = next_stamp;
            next_stamp       = next_stamp + 1;
            r.status         = ST_SET_UPDATE;
        end else begin
            r.status = ST_SET_INSERT;
            if (fill[n] >= DEPTH) begin
                // Evict the oldest stamp, lowest index on ties, then compact.
                lru    = 0;
                oldest = age_mem[n][0];
                for (int i = 1; i < DEPTH; i++)
                    if (age_mem[n][i] < oldest) begin
                        oldest = age_mem[n][i];
                        lru    = i;
                    end
                for (int i = lru; i + 1 < DEPTH; i++) begin
                    tag_mem[n][i]  = tag_mem[n][i+1];
                    data_mem[n][i] = data_mem[n][i+1];
                    age_mem[n][i]  = age_mem[n][i+1];
                end
                fill[n]      = DEPTH - 1;
                evict_cnt[n] = evict_cnt[n] + 1;
                r.status     = ST_SET_EVICT;
            end
            tag_mem[n][fill[n]]  = it.key_tag;
            data_mem[n][fill[n]] = it.write_value;
            age_mem[n][fill[n]]  = next_stamp;
            next_stamp           = next_stamp + 1;
            fill[n]              = fill[n] + 1;
        end
        r.node_slot        = 2'(n);
        r.node_entry_count = 8'(fill[n]);
        r.node_hits        = hit_cnt[n];
        r.node_misses      = miss_cnt[n];
        r.node_evictions   = evict_cnt[n];
        r.total_requests   = req_sum;
        r.total_hits       = hit_sum;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input t_result exp,
                                          input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t MISMATCH %s\n  exp st=%0d slot=%0d rv=%h cnt=%0d h=%0d m=%0d e=%0d tr=%0d th=%0d\n  got st=%0d slot=%0d rv=%h cnt=%0d h=%0d m=%0d e=%0d tr=%0d th=%0d",
                     $realtime, what,
                     exp.status, exp.node_slot, exp.read_value, exp.node_entry_count,
                     exp.node_hits, exp.node_misses, exp.node_evictions,
                     exp.total_requests, exp.total_hits,
                     got.status, got.node_slot, got.read_value, got.node_entry_count,
                     got.node_hits, got.node_misses, got.node_evictions,
                     got.total_requests, got.total_hits);
    endfunction

    // Result monitor: every strobe beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, o_result);
            end else begin
                exp = pending_results.pop_front();
                if (o_result.status === ST_SET_EVICT) evictions_seen++;
                if (o_result.status === ST_GET_HIT) hits_seen++;
                if (o_result.status !== exp.status ||
                    o_result.node_slot !== exp.node_slot ||
                    o_result.read_value !== exp.read_value ||
                    o_result.node_entry_count !== exp.node_entry_count ||
                    o_result.node_hits !== exp.node_hits ||
                    o_result.node_misses !== exp.node_misses ||
                    o_result.node_evictions !== exp.node_evictions ||
                    o_result.total_requests !== exp.total_requests ||
                    o_result.total_hits !== exp.total_hits)
                    note_mismatch("result field", exp, o_result);
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers. Called at a falling edge; return at a falling edge.
    // ---------------------------------------------------------------
    int idle_pct;

    // Present one item, idle first at random, and hold it until the block takes it.
    task automatic send_item(input t_item it, output t_result exp);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp = cache_access(it);
        pending_results.push_back(exp);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop start and wait for every expected beat to come back.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [RING_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_NODE_COUNT) nodes_in_use = data[2:0];
        else ring_cfg[int'(idx) - 1] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Directed table: config rows and item rows, some with a known status.
    // ---------------------------------------------------------------
    typedef struct {
        bit                is_cfg;
        t_cfg_idx          cfg_idx;
        logic [RING_W-1:0] cfg_data;
        t_item             item;
        bit                has_status;
        t_status           want;
    } t_row;

    t_row plan[$];

    task automatic plan_cfg(input t_cfg_idx idx, input logic [RING_W-1:0] data);
        t_row r;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        r.item = '0;
        r.has_status = 1'b0;
        r.want = ST_GET_HIT;
        plan.push_back(r);
    endtask

    task automatic plan_item(input logic kind, input logic [63:0] key, input logic [9:0] hash,
                             input logic [63:0] val, input bit known, input t_status st);
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg_idx = CFG_NODE_COUNT;
        r.cfg_data = '0;
        r.item = '{kind: kind, key_tag: key, key_ring_hash: hash, write_value: val};
        r.has_status = known;
        r.want = st;
        plan.push_back(r);
    endtask

    function automatic logic [RING_W-1:0] random_ring();
        logic [RING_W-1:0] v;
        for (int j = 0; j < VNODES; j++) begin
            case ($urandom_range(0, 5))
                0: v[POS_W*j +: POS_W] = '0;
                1: v[POS_W*j +: POS_W] = 10'd999;
                2: v[POS_W*j +: POS_W] = 10'h3ff;
                default: v[POS_W*j +: POS_W] = POS_W'($urandom_range(0, 1023));
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Key pool shared by the random-item phases so gets and updates find earlier keys.
    logic [63:0] key_pool[$];

    function automatic t_item random_item(input int set_pct);
        t_item it;
        it.kind          = ($urandom_range(0, 99) < set_pct) ? KIND_SET : KIND_GET;
        it.key_ring_hash = 10'($urandom_range(0, 1023));
        it.write_value   = rand64();
        if (key_pool.size() == 0 || $urandom_range(0, 99) < 30) begin
            it.key_tag = ($urandom_range(0, 9) == 0) ? {64{$urandom_range(0, 1) == 1}} : rand64();
            key_pool.push_back(it.key_tag);
            if (key_pool.size() > 24) void'(key_pool.pop_front());
        end else begin
            it.key_tag = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        return it;
    endfunction

    initial begin
        t_result exp;
        t_item   it;
        logic [63:0] filler[$];

        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        idle_pct    = 0;
        mismatches  = 0;
        items_sent  = 0;
        evictions_seen = 0;
        hits_seen   = 0;
        nodes_in_use = '0;
        req_sum = '0; hit_sum = '0; next_stamp = '0;
        for (int s = 0; s < SLOTS; s++) begin
            ring_cfg[s] = '0; fill[s] = 0;
            hit_cnt[s] = '0; miss_cnt[s] = '0; evict_cnt[s] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // No node in use: nothing routes, gets still count as requests.
        plan_cfg(CFG_NODE_COUNT, 0);
        plan_item(KIND_GET, 64'd0, 10'd0, 64'd0, 1, ST_NO_NODE);
        plan_item(KIND_SET, '1, 10'h3ff, '1, 1, ST_NO_NODE);
        // Rings with out-of-ring positions and distance ties across slots.
        plan_cfg(CFG_RING_SLOT0, {10'h3ff, 10'd500, 10'd0});
        plan_cfg(CFG_RING_SLOT1, {10'd999, 10'd500, 10'd250});
        plan_cfg(CFG_RING_SLOT2, '0);
        plan_cfg(CFG_RING_SLOT3, '1);
        plan_cfg(CFG_NODE_COUNT, 7);   // above the slot count, clamps to four
        plan_item(KIND_SET, 64'd0, 10'd0, 64'd0, 1, ST_SET_INSERT);
        plan_item(KIND_GET, 64'd0, 10'd0, 64'd0, 1, ST_GET_HIT);
        plan_item(KIND_GET, 64'd1, 10'd0, '1, 1, ST_GET_MISS);
        plan_item(KIND_SET, 64'd0, 10'd0, '1, 1, ST_SET_UPDATE);
        plan_item(KIND_GET, 64'd0, 10'd1000, 64'd0, 1, ST_GET_HIT);
        plan_item(KIND_SET, '1, 10'd999, '1, 1, ST_SET_INSERT);
        plan_item(KIND_GET, '1, 10'd999, 64'd0, 1, ST_GET_HIT);
        plan_item(KIND_SET, '1, 10'h3ff, 64'h5555_5555_5555_5555, 1, ST_SET_INSERT);
        plan_item(KIND_GET, {32{2'b10}}, 10'd500, 64'd0, 1, ST_GET_MISS);
        plan_item(KIND_SET, {32{2'b01}}, 10'd501, {32{2'b10}}, 0, ST_GET_HIT);
        plan_item(KIND_GET, {32{2'b01}}, 10'd501, 64'd0, 0, ST_GET_HIT);
        plan_item(KIND_GET, '1, 10'h3ff, 64'd0, 0, ST_GET_HIT);

        idle_pct = 27;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                cfg_write(plan[i].cfg_idx, plan[i].cfg_data);
            end else begin
                send_item(plan[i].item, exp);
                if (plan[i].has_status && exp.status != plan[i].want)
                    note_mismatch("directed status", exp, exp);
            end
        end

        // Phase one: a single node, set-heavy with fresh keys to force evictions.
        drain();
        cfg_write(CFG_RING_SLOT0, random_ring());
        cfg_write(CFG_NODE_COUNT, 1);
        for (int i = 0; i < 450; i++) begin
            if (filler.size() != 0 && $urandom_range(0, 3) == 0) begin
                it.kind = ($urandom_range(0, 1) == 1) ? KIND_SET : KIND_GET;
                it.key_tag = filler[$urandom_range(0, filler.size() - 1)];
            end else begin
                it.kind = KIND_SET;
                it.key_tag = rand64();
                filler.push_back(it.key_tag);
            end
            it.key_ring_hash = 10'($urandom_range(0, 1023));
            it.write_value   = rand64();
            send_item(it, exp);
        end

        // Phase two: sender mostly idle, several nodes, shared key pool.
        drain();
        idle_pct = 85;
        for (int s = 0; s < SLOTS; s++) cfg_write(t_cfg_idx'(s + 1), random_ring());
        cfg_write(CFG_NODE_COUNT, 3'($urandom_range(2, 4)));
        for (int i = 0; i < 750; i++) begin
            it = random_item(50);
            send_item(it, exp);
        end

        // Phase three: no idling, clamped node count, then all four slots again.
        drain();
        idle_pct = 0;
        for (int s = 0; s < SLOTS; s++) cfg_write(t_cfg_idx'(s + 1), random_ring());
        cfg_write(CFG_NODE_COUNT, 7);
        for (int i = 0; i < 400; i++) begin
            it = random_item(45);
            send_item(it, exp);
        end
        drain();
        cfg_write(CFG_RING_SLOT2, {10'd999, 10'd999, 10'd999});
        cfg_write(CFG_NODE_COUNT, 4);
        for (int i = 0; i < 400; i++) begin
            it = random_item(45);
            send_item(it, exp);
        end

        // Let the last beats land, then the block settle.
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d gets and sets over four ring settings; saw %0d hits and %0d evictions.",
                 items_sent, hits_seen, evictions_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/chrlc_pkg.sv
sv/chrlc_ring_cell.sv
sv/chrlc_table.sv
sv/consistent_hash_routed_lru_cache_top.sv
sv/chrlc_checker.sv
tb/sv/tb_consistent_hash_routed_lru_cache_top.sv
